@@ design/lexical_token_classifier_defines.svh @@
// Assertion macros for the checker file of this block.
`ifndef LEXICAL_TOKEN_CLASSIFIER_DEFINES_SVH
`define LEXICAL_TOKEN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ltc_pkg.sv @@
package ltc_pkg;

    localparam int KW_COUNT = 16;
    localparam int KW_COLS  = 8;

    // Token class codes.
    localparam logic [1:0] CLASS_KEYWORD = 2'd0;
    localparam logic [1:0] CLASS_IDENT   = 2'd1;
    localparam logic [1:0] CLASS_INTEGER = 2'd2;
    localparam logic [1:0] CLASS_FLOAT   = 2'd3;

    // Characters with a special role in the number tests.
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_EXP_LO  = 8'h65;
    localparam logic [7:0] CH_EXP_HI  = 8'h45;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Keyword spelling, padded with zeros to eight columns.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_COLS] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"c", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6, 3'd3, 3'd6
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        logic [1:0] token_class;
        logic       malformed_number;
    } out_word_t;

    typedef struct packed {
        logic [KW_COUNT-1:0] keyword_hits;
        logic [2:0]          char_position;
        logic                integer_ok;
        logic                float_ok;
        logic [1:0]          period_count;
        logic [1:0]          exponent_count;
        logic [1:0]          exponent_sign_count;
        logic                previous_was_exponent;
    } tok_state_t;

    localparam tok_state_t STATE_RESET = '{
        keyword_hits:          {KW_COUNT{1'b1}},
        char_position:         3'd0,
        integer_ok:            1'b1,
        float_ok:              1'b1,
        period_count:          2'd0,
        exponent_count:        2'd0,
        exponent_sign_count:   2'd0,
        previous_was_exponent: 1'b0
    };

    // Two-bit counter that sticks at three.
    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        return (v == 2'd3) ? 2'd3 : v + 2'd1;
    endfunction

endpackage

@@ design/ltc_step.sv @@
module ltc_step (
    input  ltc_pkg::tok_state_t st,
    input  ltc_pkg::in_word_t   word,
    output ltc_pkg::tok_state_t st_next,
    output ltc_pkg::out_word_t  res
);
    import ltc_pkg::*;

    logic                is_digit;
    logic                is_sign;
    logic                is_expo;
    logic [KW_COUNT-1:0] hits_next;
    logic [KW_COUNT-1:0] len_match;
    logic [3:0]          pos_plus;
    logic                excess;
    logic                is_keyword;

    // Character classes.
    assign is_digit = (word.ch >= CH_ZERO) && (word.ch <= CH_NINE);
    assign is_sign  = (word.ch == CH_PLUS) || (word.ch == CH_MINUS);
    assign is_expo  = (word.ch == CH_EXP_LO) || (word.ch == CH_EXP_HI);
    assign pos_plus = {1'b0, st.char_position} + 4'd1;

    // Keyword flags: one compare per keyword at the current column.
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hits_next[k] = st.keyword_hits[k] && (st.char_position < KW_LEN[k]) &&
                           (KW_TEXT[k][st.char_position] == word.ch);
            len_match[k] = (pos_plus == {1'b0, KW_LEN[k]});
        end
    end

    // Number tests and counters.
    always_comb
    begin
        st_next = st;
        st_next.keyword_hits = hits_next;
        if (st.char_position == 3'd0)
        begin
            if (!(is_sign || is_digit))
            begin
                st_next.integer_ok = 1'b0;
                st_next.float_ok   = 1'b0;
            end
        end
        else
        begin
            if (!is_digit)
            begin
                st_next.integer_ok = 1'b0;
            end
            if (is_digit)
            begin
                st_next.float_ok = st.float_ok;
            end
            else if (word.ch == CH_PERIOD)
            begin
                st_next.period_count = sat_inc(st.period_count);
            end
            else if (is_expo)
            begin
                st_next.exponent_count = sat_inc(st.exponent_count);
            end
            else if (is_sign && st.previous_was_exponent)
            begin
                st_next.exponent_sign_count = sat_inc(st.exponent_sign_count);
            end
            else
            begin
                st_next.float_ok = 1'b0;
            end
        end
        st_next.previous_was_exponent = is_expo;
        if (st.char_position != 3'd7)
        begin
            st_next.char_position = st.char_position + 3'd1;
        end
    end

    // Classification from the updated flags.
    assign excess = st_next.period_count[1] || st_next.exponent_count[1] ||
                    st_next.exponent_sign_count[1];
    assign is_keyword = |(hits_next & len_match);

    always_comb
    begin
        res.malformed_number = st_next.float_ok && excess;
        if (is_keyword)
        begin
            res.token_class = CLASS_KEYWORD;
        end
        else if (st_next.integer_ok)
        begin
            res.token_class = CLASS_INTEGER;
        end
        else if (st_next.float_ok && !excess)
        begin
            res.token_class = CLASS_FLOAT;
        end
        else
        begin
            res.token_class = CLASS_IDENT;
        end
    end

endmodule

@@ design/lexical_token_classifier.sv @@
// Lexical token classifier. Feed one character per word on in_word, with
// last_char set on the final character of each token; one result word then
// comes out with the token's class (keyword, identifier, signed integer or
// signed float) and a flag for numbers with too many periods, exponents or
// exponent signs. The block takes one character every cycle while in_stall is
// low; a token's result is registered into out_word, or into a one-word skid
// register while out_word is held. These two registers separate the channels,
// so in_stall rises only when both hold results that the consumer has not taken.
module lexical_token_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ltc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output ltc_pkg::out_word_t  out_word
);
    import ltc_pkg::*;

    tok_state_t state_reg;
    tok_state_t state_next;
    tok_state_t step_state;
    out_word_t  step_res;
    out_word_t  out_word_reg;
    out_word_t  out_word_next;
    out_word_t  skid_word_reg;
    out_word_t  skid_word_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic       in_take;
    logic       out_take;
    logic       produce;

    ltc_step u_step (
        .st      (state_reg),
        .word    (in_word),
        .st_next (step_state),
        .res     (step_res)
    );

    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign produce  = in_take && in_word.last_char;

    // Token state advances on each taken character and clears after the last.
    always_comb
    begin
        state_next = state_reg;
        if (in_take)
        begin
            state_next = in_word.last_char ? STATE_RESET : step_state;
        end
    end

    // Output register with a skid word behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (produce)
            begin
                out_valid_next = 1'b1;
                out_word_next  = step_res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = step_res;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ design/ltc_checker.sv @@
`include "lexical_token_classifier_defines.svh"

module ltc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ltc_pkg::in_word_t  in_word,
    input logic               out_valid,
    input logic               out_stall,
    input ltc_pkg::out_word_t out_word
);
    import ltc_pkg::*;

    // A stalled result stays put.
    `LTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

    // A fresh result follows a taken final character.
    `LTC_ASSERT_IMP(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall && in_word.last_char), "result without a final character")

    // The input stalls only when the output was blocked.
    `LTC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && $past(out_valid && out_stall), "input stalled without output back-pressure")

    // A malformed number is never classed as anything but an identifier.
    `LTC_ASSERT_IMP(a_malformed_ident, clk, rst_n, out_valid && out_word.malformed_number, out_word.token_class == CLASS_IDENT, "malformed number with a number class")

endmodule

bind lexical_token_classifier ltc_checker u_ltc_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import ltc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_TICKS = 10;
    localparam int WORD_TARGET = 1900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TICKS = 8;
    localparam int HOLD_TICKS  = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;

    lexical_token_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Keyword spellings in the order of the keyword flag bits.
    string kw_spelling [KW_COUNT] = '{
        "if", "for", "else", "while", "cin", "cout", "bool", "case",
        "const", "float", "false", "true", "void", "switch", "int", "double"
    };

    in_word_t   char_queue [$];
    out_word_t  class_queue [$];
    logic [7:0] tok_buf [$];
    tok_state_t scan_st;
    int         error_count = 0;
    int         results_seen = 0;
    int         cycle_count = 0;

    // Two-bit counter that stops at three.
    function automatic logic [1:0] bump_count(input logic [1:0] v);
        return (v == 2'd3) ? v : v + 2'd1;
    endfunction

    // Put the scanner back to the state of a fresh token.
    function automatic void clear_scan();
        scan_st.keyword_hits          = '1;
        scan_st.char_position         = 3'd0;
        scan_st.integer_ok            = 1'b1;
        scan_st.float_ok              = 1'b1;
        scan_st.period_count          = 2'd0;
        scan_st.exponent_count        = 2'd0;
        scan_st.exponent_sign_count   = 2'd0;
        scan_st.previous_was_exponent = 1'b0;
    endfunction

    // Advance the scanner by one character; returns 1 when a class is due.
    function automatic bit scan_char(input in_word_t w, output out_word_t res);
        logic [7:0] c;
        logic [2:0] pos;
        bit         is_digit;
        bit         is_sign;
        bit         is_exp;
        bit         kw_found;
        bit         excess;
        int         k;
        c        = w.ch;
        pos      = scan_st.char_position;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        is_exp   = (c == CH_EXP_LO) || (c == CH_EXP_HI);
        res      = '0;

        for (k = 0; k < KW_COUNT; k++)
        begin
            if (!(int'(pos) < kw_spelling[k].len() && kw_spelling[k][pos] == c))
                scan_st.keyword_hits[k] = 1'b0;
        end

        // Number tests: the first character must be a sign or a digit.
        if (pos == 3'd0)
        begin
            if (!(is_sign || is_digit))
            begin
                scan_st.integer_ok = 1'b0;
                scan_st.float_ok   = 1'b0;
            end
        end
        else
        begin
            if (!is_digit)
                scan_st.integer_ok = 1'b0;
            if (is_digit)
                ;
            else if (c == CH_PERIOD)
                scan_st.period_count = bump_count(scan_st.period_count);
            else if (is_exp)
                scan_st.exponent_count = bump_count(scan_st.exponent_count);
            else if (is_sign && scan_st.previous_was_exponent)
                scan_st.exponent_sign_count = bump_count(scan_st.exponent_sign_count);
            else
                scan_st.float_ok = 1'b0;
        end
        scan_st.previous_was_exponent = is_exp;
        if (scan_st.char_position != 3'd7)
            scan_st.char_position = scan_st.char_position + 3'd1;

        if (!w.last_char)
            return 0;

        kw_found = 0;
        for (k = 0; k < KW_COUNT; k++)
        begin
            if (scan_st.keyword_hits[k] && int'(pos) + 1 == kw_spelling[k].len())
                kw_found = 1;
        end
        excess = (scan_st.period_count > 2'd1) || (scan_st.exponent_count > 2'd1)
                 || (scan_st.exponent_sign_count > 2'd1);
        if (kw_found)
            res.token_class = CLASS_KEYWORD;
        else if (scan_st.integer_ok)
            res.token_class = CLASS_INTEGER;
        else if (scan_st.float_ok && !excess)
            res.token_class = CLASS_FLOAT;
        else
            res.token_class = CLASS_IDENT;
        res.malformed_number = scan_st.float_ok && excess;
        clear_scan();
        return 1;
    endfunction

    // Queue the characters of tok_buf as one token.
    task automatic emit_token();
        in_word_t w;
        int       i;
        for (i = 0; i < tok_buf.size(); i++)
        begin
            w.ch        = tok_buf[i];
            w.last_char = (i == tok_buf.size() - 1);
            char_queue.push_back(w);
        end
        tok_buf.delete();
    endtask

    task automatic emit_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            tok_buf.push_back(s[i]);
        emit_token();
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                    : 8'($urandom_range(65, 90));
    endfunction

    // Number-like token: mostly digits, with periods, exponents, signs and stray bytes mixed in.
    task automatic build_number();
        int n;
        int i;
        int r;
        bit prev_exp;
        tok_buf.push_back($urandom_range(0, 3) == 0 ? rand_sign() : rand_digit());
        n = $urandom_range(0, 8);
        prev_exp = 0;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (prev_exp && r >= 10)
            begin
                tok_buf.push_back(rand_sign());
                prev_exp = 0;
            end
            else if (r < 12)
            begin
                tok_buf.push_back(rand_digit());
                prev_exp = 0;
            end
            else if (r < 14)
            begin
                tok_buf.push_back(CH_PERIOD);
                prev_exp = 0;
            end
            else if (r < 17)
            begin
                tok_buf.push_back($urandom_range(0, 1) ? CH_EXP_LO : CH_EXP_HI);
                prev_exp = 1;
            end
            else if (r < 19)
            begin
                tok_buf.push_back(rand_sign());
                prev_exp = 0;
            end
            else
            begin
                tok_buf.push_back(8'($urandom_range(0, 255)));
                prev_exp = 0;
            end
        end
        emit_token();
    endtask

    // Keyword, as spelled or cut short, extended or with one character changed.
    task automatic build_keyword();
        string s;
        int    i;
        int    cut;
        int    mode;
        s = kw_spelling[$urandom_range(0, KW_COUNT - 1)];
        mode = $urandom_range(0, 5);
        cut = (mode == 1) ? $urandom_range(1, s.len() - 1) : s.len();
        for (i = 0; i < cut; i++)
            tok_buf.push_back(s[i]);
        if (mode == 2)
            tok_buf.push_back($urandom_range(0, 1) ? rand_letter() : rand_digit());
        if (mode == 3)
            tok_buf[$urandom_range(0, tok_buf.size() - 1)] = 8'($urandom_range(0, 255));
        emit_token();
    endtask

    task automatic build_identifier();
        int n;
        int i;
        n = $urandom_range(1, 11);
        tok_buf.push_back(rand_letter());
        for (i = 1; i < n; i++)
            tok_buf.push_back($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
        emit_token();
    endtask

    task automatic build_noise();
        int n;
        int i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
            tok_buf.push_back(8'($urandom_range(0, 255)));
        emit_token();
    endtask

    task automatic build_integer();
        int n;
        int i;
        n = $urandom_range(0, 9);
        tok_buf.push_back($urandom_range(0, 2) == 0 ? rand_sign() : rand_digit());
        for (i = 0; i < n; i++)
            tok_buf.push_back(rand_digit());
        emit_token();
    endtask

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Stimulus, then the wait for the last result and the verdict.
    initial
    begin
        clear_scan();

        // Directed tokens: a keyword, lone sign and digit, a good float,
        // repeated periods, extreme bytes, a misplaced sign, doubled exponents.
        emit_text("if");
        emit_text("-");
        emit_text("9");
        emit_text("1.5e+3");
        emit_text("1..2");
        tok_buf.push_back(8'hFF);
        emit_token();
        tok_buf.push_back(8'h00);
        emit_token();
        emit_text("4+1");
        emit_text("+e-e");

        while (char_queue.size() < WORD_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: build_number();
                3, 4:    build_keyword();
                5, 6:    build_identifier();
                7:       build_integer();
                8:       build_noise();
                default:
                begin
                    tok_buf.push_back(8'($urandom_range(0, 255)));
                    emit_token();
                end
            endcase
        end

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || class_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("FAIL");
            $finish;
        end
    end

    // Sender: offers words in bursts with gaps, and scores each accepted word.
    int        burst_left = 0;
    int        gap_left = 0;
    out_word_t due_class;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_word    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (scan_char(in_word, due_class))
                    class_queue.push_back(due_class);
                void'(char_queue.pop_front());
            end

            // A stalled word stays on the bus unchanged.
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_word  <= char_queue[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted result and stalls on its own pattern,
    // with one long hold-off that lets the block fill up.
    int        seg_left = 0;
    int        stall_rate = 0;
    int        hold_left = 0;
    bit        hold_done = 0;
    out_word_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            seg_left   <= 0;
            stall_rate <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (class_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got class %0d malformed %0d",
                             $time, out_word.token_class, out_word.malformed_number);
                    error_count++;
                end
                else
                begin
                    want = class_queue.pop_front();
                    if (out_word.token_class !== want.token_class)
                    begin
                        $display("%0t: token_class expected %0d, got %0d",
                                 $time, want.token_class, out_word.token_class);
                        error_count++;
                    end
                    if (out_word.malformed_number !== want.malformed_number)
                    begin
                        $display("%0t: malformed_number expected %0d, got %0d",
                                 $time, want.malformed_number, out_word.malformed_number);
                        error_count++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 100)
            begin
                hold_done = 1;
                hold_left <= HOLD_TICKS;
                out_stall <= 1'b1;
            end
            else
            begin
                // Stall rate changes per segment; rate zero gives stall-free stretches.
                if (seg_left == 0)
                begin
                    seg_left   <= $urandom_range(16, 96);
                    stall_rate <= $urandom_range(0, 5);
                end
                else
                    seg_left <= seg_left - 1;
                out_stall <= ($urandom_range(0, 7) < stall_rate);
            end
        end
    end

endmodule
